>>> design/ransac_point_consensus_unit_macros.svh
// ----------------------------------------------------------------------------
// ransac point consensus assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RANSAC_POINT_CONSENSUS_UNIT_MACROS_SVH
`define RANSAC_POINT_CONSENSUS_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define RPC_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define RPC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// shared constants, codes and types of the point consensus unit
// ----------------------------------------------------------------------------
package rpc_pkg;

    // default sizing
    localparam int DEF_MAX_POINTS  = 1024;
    localparam int DEF_COORD_BITS  = 16;

    // fixed field widths
    localparam int MODE_W      = 2;
    localparam int CAND_W      = 10;
    localparam int OUT_CNT_W   = 11;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LIM_W       = 2 * CFG_DATA_W;

    // operation modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUDGET     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 2'd1;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 16'd26;
    localparam logic [CFG_DATA_W-1:0] BUDGET_RST    = 16'd100;

    // distance pipeline status toward the sequencer
    typedef struct packed {
        logic valid;    // a point result leaves the pipeline this cycle
        logic inlier;   // that point lies inside the threshold
        logic busy;     // some stage still holds a point
    } rpc_hit_t;

endpackage

>>> design/rpc_ram.sv
// ----------------------------------------------------------------------------
// rpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rpc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rpc_dist_pipe.sv
// ----------------------------------------------------------------------------
// rpc_dist_pipe
// three stage squared distance pipeline with threshold compare at its output
// ----------------------------------------------------------------------------
module rpc_dist_pipe #(
    parameter int COORD_BITS = rpc_pkg::DEF_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [3*COORD_BITS-1:0]   sample,
    input  logic [3*COORD_BITS-1:0]   hyp,
    input  logic [rpc_pkg::LIM_W-1:0] lim,
    output rpc_pkg::rpc_hit_t         hit
);
    import rpc_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    logic signed [DW-1:0]   diff_next [3];
    logic signed [DW-1:0]   diff_reg  [3];
    logic signed [SQ_W-1:0] sq_reg    [3];
    logic [SUM_W-1:0]       sum_reg;
    logic                   va_reg;
    logic                   vb_reg;
    logic                   vc_reg;

    // per-axis differences, sign extended by one bit
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_next[k] =
                $signed({sample[k*COORD_BITS+COORD_BITS-1], sample[k*COORD_BITS +: COORD_BITS]})
              - $signed({hyp[k*COORD_BITS+COORD_BITS-1], hyp[k*COORD_BITS +: COORD_BITS]});
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // difference, square and sum stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_reg[k] <= diff_next[k];
            sq_reg[k]   <= SQ_W'(diff_reg[k]) * SQ_W'(diff_reg[k]);
        end
        sum_reg <= SUM_W'($unsigned(sq_reg[0])) + SUM_W'($unsigned(sq_reg[1]))
                 + SUM_W'($unsigned(sq_reg[2]));
    end

    // strict compare against the squared threshold
    assign hit.valid  = vc_reg;
    assign hit.inlier = CMP_W'(sum_reg) < CMP_W'(lim);
    assign hit.busy   = va_reg | vb_reg | vc_reg;

endmodule

>>> design/ransac_point_consensus_unit.sv
// ----------------------------------------------------------------------------
// ransac_point_consensus_unit
// point store and consensus scorer for point hypotheses
// ----------------------------------------------------------------------------
// Usage: drive mode and its operands with start; a command transfers at the
// rising edge where start is high and busy is low. Each command returns one
// result, shown for exactly one cycle with done high; the receiver cannot
// stall, so it must take the result in that cycle.
// Load, clear, the unused mode and a rejected test (budget spent or index not
// loaded) return their result in the cycle after the transfer, and busy stays
// low, so such commands can be issued every cycle.
// An accepted test reads the hypothesis point, then streams every stored
// point once through the point ram read port into a three stage distance
// pipeline; busy stays high until done rises with the result. The ram read
// port, one point per cycle, sets the pace of the sweep.
// Configuration writes (threshold, trial budget) are always ready and must
// be issued only while no command is outstanding.
// Reset empties the store, clears best and trial count and restores the
// threshold (26) and budget (100); the ram contents are not cleared.
// ----------------------------------------------------------------------------
module ransac_point_consensus_unit #(
    parameter int MAX_POINTS = rpc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = rpc_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [rpc_pkg::MODE_W-1:0]     mode,
    input  logic [COORD_BITS-1:0]          coord_x,
    input  logic [COORD_BITS-1:0]          coord_y,
    input  logic [COORD_BITS-1:0]          coord_z,
    input  logic [rpc_pkg::CAND_W-1:0]     candidate_index,
    // result channel
    output logic                           done,
    output logic [rpc_pkg::OUT_CNT_W-1:0]  points_held,
    output logic [rpc_pkg::OUT_CNT_W-1:0]  trial_inliers,
    output logic                           new_best,
    output logic [rpc_pkg::OUT_CNT_W-1:0]  best_inliers,
    output logic [rpc_pkg::CAND_W-1:0]     best_index,
    output logic [rpc_pkg::STATUS_W-1:0]   status,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IC_W   = (CNT_W > CAND_W) ? CNT_W : CAND_W;
    localparam int PT_W   = 3 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HYP,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        best_cnt_reg, best_cnt_next;
    logic [CAND_W-1:0]       best_idx_reg, best_idx_next;
    logic [CFG_DATA_W-1:0]   trials_reg, trials_next;
    logic [CAND_W-1:0]       cand_reg, cand_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic [PT_W-1:0]         hyp_reg, hyp_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic                    rd_v_reg, rd_v_next;
    logic [CNT_W-1:0]        inl_reg, inl_next;
    logic [CFG_DATA_W-1:0]   threshold_reg;
    logic [CFG_DATA_W-1:0]   budget_reg;

    logic                    done_reg, done_next;
    logic [OUT_CNT_W-1:0]    held_reg, held_next;
    logic [OUT_CNT_W-1:0]    trial_reg, trial_next;
    logic                    new_best_reg, new_best_next;
    logic [OUT_CNT_W-1:0]    best_out_reg, best_out_next;
    logic [CAND_W-1:0]       best_idx_out_reg, best_idx_out_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic                    accept;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_raddr;
    logic [PT_W-1:0]         ram_rdata;
    logic                    last_issue;
    rpc_hit_t                hit;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // point store
    rpc_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(count_reg)),
        .wdata ({coord_z, coord_y, coord_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // squared distance pipeline
    rpc_dist_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_v_reg),
        .sample   (ram_rdata),
        .hyp      (hyp_reg),
        .lim      (lim_reg),
        .hit      (hit)
    );

    // store write only for a load that fits
    assign ram_we = accept && (mode == MODE_LOAD) && (count_reg != CNT_W'(MAX_POINTS));

    // read the hypothesis while idle, then sweep the stored points
    assign ram_raddr  = (state_reg == S_IDLE) ? IDX_W'(candidate_index) : ptr_reg;
    assign last_issue = (CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            budget_reg    <= BUDGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_BUDGET:    budget_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer next state and result
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        best_cnt_next     = best_cnt_reg;
        best_idx_next     = best_idx_reg;
        trials_next       = trials_reg;
        cand_next         = cand_reg;
        lim_next          = lim_reg;
        hyp_next          = hyp_reg;
        ptr_next          = ptr_reg;
        rd_v_next         = 1'b0;
        inl_next          = inl_reg;
        done_next         = 1'b0;
        held_next         = held_reg;
        trial_next        = trial_reg;
        new_best_next     = new_best_reg;
        best_out_next     = best_out_reg;
        best_idx_out_next = best_idx_out_reg;
        status_next       = status_reg;

        // count inlier points leaving the pipeline
        if (hit.valid && hit.inlier)
        begin
            inl_next = inl_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next     = 1'b1;
                    trial_next    = '0;
                    new_best_next = 1'b0;
                    status_next   = ST_OK;
                    case (mode)
                        MODE_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAX_POINTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_TEST:
                        begin
                            if (trials_reg >= budget_reg)
                            begin
                                status_next = ST_BUDGET;
                            end
                            else if (IC_W'(candidate_index) >= IC_W'(count_reg))
                            begin
                                status_next = ST_NOT_LOADED;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                trials_next = trials_reg + CFG_DATA_W'(1);
                                cand_next   = candidate_index;
                                lim_next    = LIM_W'(threshold_reg) * LIM_W'(threshold_reg);
                                ptr_next    = '0;
                                inl_next    = '0;
                                state_next  = S_HYP;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next    = '0;
                            best_cnt_next = '0;
                            best_idx_next = '0;
                            trials_next   = '0;
                        end
                        default: ;
                    endcase
                    held_next         = OUT_CNT_W'(count_next);
                    best_out_next     = OUT_CNT_W'(best_cnt_next);
                    best_idx_out_next = best_idx_next;
                end
            end
            S_HYP, S_SCAN:
            begin
                // hypothesis point arrives in the first cycle only
                if (state_reg == S_HYP)
                begin
                    hyp_next = ram_rdata;
                end
                rd_v_next  = 1'b1;
                ptr_next   = ptr_reg + IDX_W'(1);
                state_next = last_issue ? S_DRAIN : S_SCAN;
            end
            S_DRAIN:
            begin
                // all reads retired and pipeline empty: count is final
                if (!rd_v_reg && !hit.busy)
                begin
                    done_next     = 1'b1;
                    trial_next    = OUT_CNT_W'(inl_reg);
                    new_best_next = 1'b0;
                    status_next   = ST_OK;
                    if (inl_reg > best_cnt_reg)
                    begin
                        best_cnt_next = inl_reg;
                        best_idx_next = cand_reg;
                        new_best_next = 1'b1;
                    end
                    held_next         = OUT_CNT_W'(count_reg);
                    best_out_next     = OUT_CNT_W'(best_cnt_next);
                    best_idx_out_next = best_idx_next;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            trials_reg   <= '0;
            rd_v_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            best_cnt_reg <= best_cnt_next;
            best_idx_reg <= best_idx_next;
            trials_reg   <= trials_next;
            rd_v_reg     <= rd_v_next;
            done_reg     <= done_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        cand_reg         <= cand_next;
        lim_reg          <= lim_next;
        hyp_reg          <= hyp_next;
        ptr_reg          <= ptr_next;
        inl_reg          <= inl_next;
        held_reg         <= held_next;
        trial_reg        <= trial_next;
        new_best_reg     <= new_best_next;
        best_out_reg     <= best_out_next;
        best_idx_out_reg <= best_idx_out_next;
        status_reg       <= status_next;
    end

    assign done          = done_reg;
    assign points_held   = held_reg;
    assign trial_inliers = trial_reg;
    assign new_best      = new_best_reg;
    assign best_inliers  = best_out_reg;
    assign best_index    = best_idx_out_reg;
    assign status        = status_reg;

endmodule

>>> design/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// port level checks of the point consensus unit, bound to the top level
// ----------------------------------------------------------------------------
`include "ransac_point_consensus_unit_macros.svh"

module rpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [rpc_pkg::MODE_W-1:0]    mode,
    input logic                          done,
    input logic [rpc_pkg::OUT_CNT_W-1:0] trial_inliers,
    input logic                          new_best,
    input logic [rpc_pkg::OUT_CNT_W-1:0] best_inliers,
    input logic [rpc_pkg::STATUS_W-1:0]  status
);
    import rpc_pkg::*;

    // non-test commands answer in the next cycle without going busy
    `RPC_ASSERT_NEXT(a_quick_result, start && !busy && mode != MODE_TEST, done && !busy, "non-test command did not answer next cycle")

    // a test transfer either answers at once or starts the sweep
    `RPC_ASSERT_NEXT(a_test_progress, start && !busy && mode == MODE_TEST, done || busy, "test transfer neither answered nor started")

    // a new best carries its own count and a clean status
    `RPC_ASSERT_NOW(a_new_best, !(done && new_best) || (status == ST_OK && trial_inliers == best_inliers && trial_inliers != '0), "new best inconsistent with counts")

    // a result is never shown while a sweep is still running
    `RPC_ASSERT_NOW(a_done_idle, !done || !busy, "result shown while busy")

endmodule

bind ransac_point_consensus_unit rpc_checker u_rpc_checker (.*);
